@@ sv/lzd_pkg.sv @@
// Package for the LZ77 block token decoder.
// Holds the port word types, the queue entry type and the default sizes.
// No dependencies.
`default_nettype none

package lzd_pkg;

  localparam int BLOCK_BYTES_DEF = 32768;
  localparam int MAX_COPY_DEF    = 15;
  localparam int QUEUE_DEPTH     = 4;

  localparam int OFFSET_W = 15;
  localparam int LENGTH_W = 4;
  localparam int BYTE_W   = 8;

  localparam logic FUNC_COPY = 1'b0;
  localparam logic FUNC_EOB  = 1'b1;

  typedef struct packed {
    logic                func;
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
    logic [BYTE_W-1:0]   next_byte;
  } token_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last;
    logic              error;
  } result_t;

  typedef struct packed {
    logic                eob;
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] len;
    logic [BYTE_W-1:0]   lit;
  } entry_t;

endpackage

`default_nettype wire

@@ sv/lzd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/lzd_front.sv @@
// Front end of the LZ77 token decoder: accepts token words and classifies them.
// Clamps the copy length and builds queue entries. Depends on lzd_pkg.
`default_nettype none

module lzd_front #(
  parameter int MAX_COPY = lzd_pkg::MAX_COPY_DEF
) (
  input  wire logic            token_valid,
  output      logic            token_stall,
  input  wire lzd_pkg::token_t token,
  input  wire logic            q_full,
  output      logic            push,
  output      lzd_pkg::entry_t push_entry
);
  import lzd_pkg::*;

  logic [LENGTH_W-1:0] len_clamp;

  always_comb begin
    if (32'(token.length) > MAX_COPY) begin
      len_clamp = LENGTH_W'(MAX_COPY);
    end else begin
      len_clamp = token.length;
    end
  end

  assign token_stall       = q_full;
  assign push              = token_valid && !q_full;
  assign push_entry.eob    = (token.func == FUNC_EOB);
  assign push_entry.offset = token.offset;
  assign push_entry.len    = len_clamp;
  assign push_entry.lit    = token.next_byte;

endmodule

`default_nettype wire

@@ sv/lzd_queue.sv @@
// Short register queue between the decoder front end and back end.
// Depends on lzd_pkg.
`default_nettype none

module lzd_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire lzd_pkg::entry_t push_entry,
  output      logic            full,
  output      logic            q_valid,
  output      lzd_pkg::entry_t q_entry,
  input  wire logic            pop
);
  import lzd_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t        slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_entry;
        wr_ptr        <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/lzd_back.sv @@
// Back end of the LZ77 token decoder: copy sequencer, history memory and output word.
// Issues one byte per cycle while the output is not stalled; reads history at issue,
// ahead of the byte stage, with write forwarding. Depends on lzd_pkg and lzd_ram.
`default_nettype none

module lzd_back #(
  parameter int BLOCK_BYTES = lzd_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire lzd_pkg::entry_t  q_entry,
  output      logic             q_pop,
  output      logic             result_valid,
  input  wire logic             result_stall,
  output      lzd_pkg::result_t result
);
  import lzd_pkg::*;

  localparam int AW  = $clog2(BLOCK_BYTES);
  localparam int WPW = $clog2(BLOCK_BYTES + 1);
  localparam int PW  = (WPW > OFFSET_W + 1) ? WPW : OFFSET_W + 1;

  logic                busy;
  logic [PW-1:0]       pos;
  logic [LENGTH_W-1:0] rem;
  logic [BYTE_W-1:0]   lit;
  logic [WPW-1:0]      wp;

  logic                b_valid;
  logic                b_last;
  logic                b_err;
  logic                b_rerr;
  logic                b_fwd;
  logic                b_store;
  logic [AW-1:0]       b_waddr;
  logic [BYTE_W-1:0]   b_lit;
  logic [BYTE_W-1:0]   fwd_byte;

  logic                out_free;
  logic                b_done;
  logic                move;
  logic                head_copy;
  logic                head_eob;
  logic                issue;
  logic [PW-1:0]       cur_pos;
  logic [LENGTH_W-1:0] cur_rem;
  logic [BYTE_W-1:0]   cur_lit;
  logic                is_lit;
  logic                rd_ok;
  logic                full;
  logic                re;
  logic [AW-1:0]       raddr;
  logic [BYTE_W-1:0]   rdata;
  logic [BYTE_W-1:0]   b_data;
  logic                fwd_hit;

  assign out_free  = !result_valid || !result_stall;
  assign b_done    = b_valid && out_free;
  assign move      = !b_valid || b_done;
  assign head_copy = !busy && q_valid && !q_entry.eob;
  assign head_eob  = !busy && q_valid && q_entry.eob;
  assign cur_pos   = busy ? pos : PW'(q_entry.offset);
  assign cur_rem   = busy ? rem : q_entry.len;
  assign cur_lit   = busy ? lit : q_entry.lit;
  assign issue     = (busy || head_copy) && move;
  assign is_lit    = (cur_rem == '0);
  assign rd_ok     = (cur_pos < PW'(wp));
  assign full      = (wp == WPW'(BLOCK_BYTES));
  assign re        = issue && !is_lit && rd_ok;
  assign raddr     = cur_pos[AW-1:0];
  assign q_pop     = head_eob || (head_copy && move);

  always_comb begin
    if (b_last) begin
      b_data = b_lit;
    end else if (b_rerr) begin
      b_data = '0;
    end else if (b_fwd) begin
      b_data = fwd_byte;
    end else begin
      b_data = rdata;
    end
  end

  assign fwd_hit = b_done && b_store && (b_waddr == raddr);

  lzd_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(BLOCK_BYTES)
  ) u_history (
    .clk  (clk),
    .we   (b_done && b_store),
    .waddr(b_waddr),
    .wdata(b_data),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      wp           <= '0;
      b_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (b_done) begin
        result.data_byte <= b_data;
        result.last      <= b_last;
        result.error     <= b_err;
        result_valid     <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      if (move) begin
        b_valid  <= issue;
        fwd_byte <= b_data;
      end
      if (issue) begin
        b_last  <= is_lit;
        b_rerr  <= !is_lit && !rd_ok;
        b_err   <= (!is_lit && !rd_ok) || full;
        b_store <= !full;
        b_waddr <= wp[AW-1:0];
        b_lit   <= cur_lit;
        b_fwd   <= fwd_hit;
        busy    <= !is_lit;
        pos     <= cur_pos + 1'b1;
        rem     <= cur_rem - 1'b1;
        lit     <= cur_lit;
      end

      if (head_eob) begin
        wp <= '0;
      end else if (issue && !full) begin
        wp <= wp + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/lz77_block_token_decoder.sv @@
// Top level of the LZ77 block token decoder.
// Instantiates lzd_front, lzd_queue and lzd_back. Depends on lzd_pkg.
//
// A copy token of clamped length n produces n + 1 result words, one per cycle
// while the output is not stalled (at most 16 words with the default copy
// limit); an end-of-block token produces nothing. The rate is set by the
// single read port of the history memory, which serves one copied byte per
// cycle. A four-entry queue lets tokens be taken while earlier ones are still
// being expanded; the first byte of a token passes through the queue, the
// byte stage and the result register. Copies that overlap the bytes they
// write are forwarded around the memory.
`default_nettype none

module lz77_block_token_decoder #(
  parameter int BLOCK_BYTES = lzd_pkg::BLOCK_BYTES_DEF,
  parameter int MAX_COPY    = lzd_pkg::MAX_COPY_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             token_valid,
  output      logic             token_stall,
  input  wire lzd_pkg::token_t  token,
  output      logic             result_valid,
  input  wire logic             result_stall,
  output      lzd_pkg::result_t result
);
  import lzd_pkg::*;

  logic   q_full;
  logic   push;
  entry_t push_entry;
  logic   q_valid;
  entry_t q_entry;
  logic   q_pop;

  lzd_front #(
    .MAX_COPY(MAX_COPY)
  ) u_front (
    .token_valid(token_valid),
    .token_stall(token_stall),
    .token      (token),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  lzd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .pop       (q_pop)
  );

  lzd_back #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_entry     (q_entry),
    .q_pop       (q_pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

`default_nettype wire
